/* sv/rrad_pkg.sv */
// Shared types and constants for the round-robin ack distributor.
// Used by rrad_div, rrad_bank and round_robin_ack_distributor_unit.
`default_nettype none

package rrad_pkg;

  localparam int MAX_CONN = 16;
  localparam int PTR_W    = 4;
  localparam int N_W      = 5;
  localparam int CNT_W    = 32;
  localparam int ACK_W    = 16;
  localparam int CONN_W   = 8;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_ACK     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARR,
    ST_ARR_DIV,
    ST_ARR_UPD,
    ST_ACK,
    ST_ACK_PRE,
    ST_ACK_FIRST,
    ST_SCAN,
    ST_FB,
    ST_FB_DIV,
    ST_DONE
  } fsm_state_t;

  typedef struct packed {
    logic             start;
    logic [ACK_W-1:0] dividend;
    logic [N_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACK_W-1:0] quot;
    logic [N_W-1:0]   rem;
  } div_rsp_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [CNT_W-1:0] data;
  } bank_wr_t;

endpackage

`default_nettype wire

/* sv/rrad_div.sv */
// Restoring divider, one quotient bit per cycle, 16-bit dividend by 5-bit divisor.
// Depends on rrad_pkg.
`default_nettype none

module rrad_div (
  input  wire               clk,
  input  wire               rst_n,
  input  wire rrad_pkg::div_req_t req,
  output rrad_pkg::div_rsp_t rsp
);
  import rrad_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [ACK_W-1:0] quot_r, quot_nxt;
  logic [N_W-1:0]   rem_r, rem_nxt;
  logic [N_W-1:0]   dvs_r, dvs_nxt;
  logic [N_W:0]     trial;
  logic             ge;

  assign trial = {rem_r, quot_r[ACK_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'(ACK_W - 1);
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quot_nxt = {quot_r[ACK_W-2:0], ge};
      rem_nxt  = ge ? N_W'(trial - {1'b0, dvs_r}) : trial[N_W-1:0];
      cnt_nxt  = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

/* sv/rrad_bank.sv */
// Bank of per-connection pending-work counters, one read and one write address.
// Depends on rrad_pkg.
`default_nettype none

module rrad_bank (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire [rrad_pkg::PTR_W-1:0]     rd_addr,
  output logic [rrad_pkg::CNT_W-1:0]    rd_data,
  input  wire rrad_pkg::bank_wr_t       wr
);
  import rrad_pkg::*;

  logic [CNT_W-1:0] cnt_r [MAX_CONN];

  assign rd_data = cnt_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CONN; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (wr.en) begin
      cnt_r[wr.addr] <= wr.data;
    end
  end

endmodule

`default_nettype wire

/* sv/round_robin_ack_distributor_unit.sv */
// Top level of the round-robin ack distributor: sequencer, pointer and output register.
// Depends on rrad_pkg, rrad_div and rrad_bank.
//
//  channel | dir | fields
//  in_     | in  | tuser: operation; tdata: conn_index[7:0], max_ack[23:8]
//  out_    | out | tuser: found; tdata: grant_conn[3:0], grant_count[19:4]
//  cfg_    | in  | wr_data: conn_count
//
// Arrival: conn_index mod n comes from the divider and that counter is incremented;
// nothing is done if n is 0.
// Ack: a grant at the pointer if its counter covers max_ack, else a scan reading one
// counter per cycle, else a fallback of max_ack / n from the divider (0 if n is 0);
// a pointer at or past n is first fixed by a divide. All divides share one 16-step divider.
// Reset clears counters, pointer and conn_count; a stalled result holds in out_.
`default_nettype none

module round_robin_ack_distributor_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // conn_index, max_ack
  input  wire         in_tuser,   // operation
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // grant_conn, grant_count, zero pad
  output logic        out_tuser,  // found
  input  wire         cfg_wr_en,
  input  wire  [4:0]  cfg_wr_data // conn_count
);
  import rrad_pkg::*;

  fsm_state_t state_r, state_nxt;

  logic [N_W-1:0]    cc_r;
  logic [N_W-1:0]    n_r, n_nxt;
  logic              op_r, op_nxt;
  logic [CONN_W-1:0] conn_r, conn_nxt;
  logic [ACK_W-1:0]  max_r, max_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [PTR_W-1:0]  ptr_fix_r, ptr_fix_nxt;
  logic [PTR_W-1:0]  slot_r, slot_nxt;
  logic [N_W-1:0]    k_r, k_nxt;
  logic [PTR_W-1:0]  res_conn_r, res_conn_nxt;
  logic [ACK_W-1:0]  res_count_r, res_count_nxt;
  logic              res_found_r, res_found_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PTR_W-1:0]  out_conn_r, out_conn_nxt;
  logic [ACK_W-1:0]  out_count_r, out_count_nxt;
  logic              out_found_r, out_found_nxt;

  logic              in_fire;
  logic              out_load;
  logic [N_W-1:0]    n_cfg;
  logic [N_W-1:0]    ptr_inc;
  logic [PTR_W-1:0]  ptr_adv;
  logic [PTR_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  rd_data;
  logic [ACK_W-1:0]  scan_grant;
  logic [N_W-1:0]    k_inc;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  bank_wr_t          bank_wr;

  rrad_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rrad_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (bank_wr)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign n_cfg     = (cc_r > N_W'(MAX_CONN)) ? N_W'(MAX_CONN) : cc_r;
  assign ptr_inc   = {1'b0, ptr_r} + N_W'(1);
  assign k_inc     = k_r + N_W'(1);
  assign scan_grant = (rd_data > {{(CNT_W-ACK_W){1'b0}}, max_r}) ? max_r : rd_data[ACK_W-1:0];

  // advance pointer modulo n (hold when n is 0); a pointer at or past n takes the value the divider fixed
  always_comb begin
    if (n_r == '0) begin
      ptr_adv = ptr_r;
    end else if ({1'b0, ptr_r} >= n_r) begin
      ptr_adv = ptr_fix_r;
    end else if (ptr_inc == n_r) begin
      ptr_adv = '0;
    end else begin
      ptr_adv = ptr_inc[PTR_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tuser == OP_ACK) ? ST_ACK : ST_ARR;
        end
      end
      ST_ARR: begin
        state_nxt = (n_r == '0) ? ST_IDLE : ST_ARR_DIV;
      end
      ST_ARR_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_ARR_UPD;
        end
      end
      ST_ARR_UPD: begin
        state_nxt = ST_IDLE;
      end
      ST_ACK: begin
        state_nxt = (n_r != '0 && {1'b0, ptr_r} >= n_r) ? ST_ACK_PRE : ST_ACK_FIRST;
      end
      ST_ACK_PRE: begin
        if (div_rsp.done) begin
          state_nxt = ST_ACK_FIRST;
        end
      end
      ST_ACK_FIRST: begin
        if (rd_data >= {{(CNT_W-ACK_W){1'b0}}, max_r}) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = (n_r == '0) ? ST_FB : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_grant != '0) begin
          state_nxt = ST_DONE;
        end else if (k_inc == n_r) begin
          state_nxt = ST_FB;
        end
      end
      ST_FB: begin
        state_nxt = (n_r == '0) ? ST_DONE : ST_FB_DIV;
      end
      ST_FB_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_nxt            = n_r;
    op_nxt           = op_r;
    conn_nxt         = conn_r;
    max_nxt          = max_r;
    ptr_nxt          = ptr_r;
    ptr_fix_nxt      = ptr_fix_r;
    slot_nxt         = slot_r;
    k_nxt            = k_r;
    res_conn_nxt     = res_conn_r;
    res_count_nxt    = res_count_r;
    res_found_nxt    = res_found_r;
    rd_addr          = ptr_r;
    bank_wr.en       = 1'b0;
    bank_wr.addr     = ptr_r;
    bank_wr.data     = rd_data - {{(CNT_W-ACK_W){1'b0}}, scan_grant};
    div_req.start    = 1'b0;
    div_req.dividend = {{(ACK_W-CONN_W){1'b0}}, conn_r};
    div_req.divisor  = n_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_tuser;
          conn_nxt = in_tdata[7:0];
          max_nxt  = in_tdata[23:8];
          n_nxt    = n_cfg;
        end
      end
      ST_ARR: begin
        div_req.start = (n_r != '0);
      end
      ST_ARR_DIV: begin
        if (div_rsp.done) begin
          slot_nxt = div_rsp.rem[PTR_W-1:0];
        end
      end
      ST_ARR_UPD: begin
        rd_addr      = slot_r;
        bank_wr.en   = (op_r == OP_ARRIVAL);
        bank_wr.addr = slot_r;
        bank_wr.data = rd_data + CNT_W'(1);
      end
      ST_ACK: begin
        div_req.start    = (n_r != '0 && {1'b0, ptr_r} >= n_r);
        div_req.dividend = {{(ACK_W-N_W){1'b0}}, ptr_inc};
      end
      ST_ACK_PRE: begin
        if (div_rsp.done) begin
          ptr_fix_nxt = div_rsp.rem[PTR_W-1:0];
        end
      end
      ST_ACK_FIRST: begin
        k_nxt = '0;
        if (rd_data >= {{(CNT_W-ACK_W){1'b0}}, max_r}) begin
          bank_wr.en    = 1'b1;
          bank_wr.data  = rd_data - {{(CNT_W-ACK_W){1'b0}}, max_r};
          res_conn_nxt  = ptr_r;
          res_count_nxt = max_r;
          res_found_nxt = 1'b1;
          ptr_nxt       = ptr_adv;
        end
      end
      ST_SCAN: begin
        ptr_nxt = ptr_adv;
        k_nxt   = k_inc;
        if (scan_grant != '0) begin
          bank_wr.en    = 1'b1;
          res_conn_nxt  = ptr_r;
          res_count_nxt = scan_grant;
          res_found_nxt = 1'b1;
        end
      end
      ST_FB: begin
        if (n_r == '0) begin
          res_conn_nxt  = ptr_r;
          res_count_nxt = '0;
          res_found_nxt = 1'b0;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = max_r;
        end
      end
      ST_FB_DIV: begin
        if (div_rsp.done) begin
          res_conn_nxt  = ptr_r;
          res_count_nxt = div_rsp.quot;
          res_found_nxt = 1'b0;
          ptr_nxt       = ptr_adv;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_conn_nxt  = out_conn_r;
    out_count_nxt = out_count_r;
    out_found_nxt = out_found_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_conn_nxt  = res_conn_r;
      out_count_nxt = res_count_r;
      out_found_nxt = res_found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cc_r        <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cc_r <= cfg_wr_data;
      end
    end
    n_r         <= n_nxt;
    op_r        <= op_nxt;
    conn_r      <= conn_nxt;
    max_r       <= max_nxt;
    ptr_fix_r   <= ptr_fix_nxt;
    slot_r      <= slot_nxt;
    k_r         <= k_nxt;
    res_conn_r  <= res_conn_nxt;
    res_count_r <= res_count_nxt;
    res_found_r <= res_found_nxt;
    out_conn_r  <= out_conn_nxt;
    out_count_r <= out_count_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_count_r, out_conn_r};
  assign out_tuser  = out_found_r;

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for round_robin_ack_distributor_unit: arrival and ack beats in, grants out.
// Holds its own backlog and pointer model in a small class; depends on rrad_pkg and the RTL.

typedef struct packed {
  logic [3:0]  conn;
  logic [15:0] count;
  logic        found;
} grant_t;

class grant_ledger;
  logic [31:0] conn_backlog [rrad_pkg::MAX_CONN];
  logic [3:0]  rr_ptr;
  logic [4:0]  conn_count;
  grant_t      expected_grants [$];
  int          errors;
  int          beats;
  int          grants;
  int          fallbacks;
  int          settings;

  function new();
    int k;
    for (k = 0; k < rrad_pkg::MAX_CONN; k++) conn_backlog[k] = '0;
    rr_ptr     = '0;
    conn_count = '0;
    errors     = 0;
    beats      = 0;
    grants     = 0;
    fallbacks  = 0;
    settings   = 0;
  endfunction

  function void set_conn_count(input logic [4:0] value);
    conn_count = value;
    settings++;
  endfunction

  function void step_ptr(input int n);
    if (n > 0) rr_ptr = 4'((int'(rr_ptr) + 1) % n);
  endfunction

  function void queue_grant(input grant_t g);
    expected_grants.insert(expected_grants.size(), g);
  endfunction

  function void note_beat(input logic op, input logic [7:0] conn, input logic [15:0] max_ack);
    int          n;
    int          k;
    logic [31:0] take;
    grant_t      g;
    beats++;
    n = (conn_count > rrad_pkg::MAX_CONN) ? rrad_pkg::MAX_CONN : int'(conn_count);
    if (op == rrad_pkg::OP_ARRIVAL) begin
      if (n > 0) conn_backlog[int'(conn) % n] = conn_backlog[int'(conn) % n] + 32'd1;
      return;
    end
    g.found = 1'b1;
    if (conn_backlog[rr_ptr] >= {16'd0, max_ack}) begin
      g.conn = rr_ptr;
      g.count = max_ack;
      conn_backlog[rr_ptr] = conn_backlog[rr_ptr] - {16'd0, max_ack};
      step_ptr(n);
      queue_grant(g);
      return;
    end
    for (k = 0; k < n; k++) begin
      take = (conn_backlog[rr_ptr] > {16'd0, max_ack}) ? {16'd0, max_ack} : conn_backlog[rr_ptr];
      if (take != 32'd0) begin
        g.conn = rr_ptr;
        g.count = take[15:0];
        conn_backlog[rr_ptr] = conn_backlog[rr_ptr] - take;
        step_ptr(n);
        queue_grant(g);
        return;
      end
      step_ptr(n);
    end
    g.conn  = rr_ptr;
    g.count = (n > 0) ? 16'(int'(max_ack) / n) : 16'd0;
    g.found = 1'b0;
    step_ptr(n);
    queue_grant(g);
  endfunction

  function void check_grant(input logic [23:0] tdata, input logic found);
    grant_t g;
    grants++;
    if (expected_grants.size() == 0) begin
      errors++;
      $display("%0t: unexpected grant conn=%0d count=%0d found=%b", $time,
               tdata[3:0], tdata[19:4], found);
      return;
    end
    g = expected_grants.pop_front();
    if (!g.found) fallbacks++;
    if (tdata[3:0] !== g.conn) begin
      errors++;
      $display("%0t: grant_conn expected %0d actual %0d", $time, g.conn, tdata[3:0]);
    end
    if (tdata[19:4] !== g.count) begin
      errors++;
      $display("%0t: grant_count expected %0d actual %0d", $time, g.count, tdata[19:4]);
    end
    if (found !== g.found) begin
      errors++;
      $display("%0t: found expected %b actual %b", $time, g.found, found);
    end
    if (tdata[23:20] !== 4'd0) begin
      errors++;
      $display("%0t: tdata pad expected 0 actual %h", $time, tdata[23:20]);
    end
  endfunction
endclass

module tb;
  import rrad_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en   = 1'b0;
  logic [4:0]  cfg_wr_data = '0;

  bit          calm     = 1'b0;
  bit          hold_req = 1'b0;
  int          cycle_cnt = 0;
  grant_ledger ledger   = new();

  round_robin_ack_distributor_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) ledger.note_beat(in_tuser, in_tdata[7:0], in_tdata[23:8]);
    if (rst_n && out_tvalid && out_tready) ledger.check_grant(out_tdata, out_tuser);
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] conn, input logic [15:0] max_ack);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {max_ack, conn};
    do @(posedge clk); while (!in_tready);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_conn_count(input logic [4:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ledger.set_conn_count(value);
  endtask

  function automatic logic [15:0] pick_max_ack();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 70) return 16'($urandom_range(1, 4));
    if (r < 90) return 16'($urandom_range(5, 40));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic random_beats(input int count);
    int k;
    int burst;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(OP_ACK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      end else begin
        burst = $urandom_range(0, 4);
        repeat (burst) send_beat(OP_ARRIVAL, 8'($urandom_range(0, 255)), 16'($urandom));
        send_beat(OP_ACK, 8'($urandom_range(0, 255)), pick_max_ack());
        k += burst;
      end
    end
  endtask

  initial begin
    logic [4:0] phase_n [12];
    int         p;
    phase_n = '{5'd1, 5'd16, 5'd5, 5'd0, 5'd31, 5'd9, 5'd16, 5'd2, 5'd17, 5'd12, 5'd3, 5'd16};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(OP_ARRIVAL, 8'hFF, 16'hFFFF);
    send_beat(OP_ACK, 8'h00, 16'h0000);
    send_beat(OP_ACK, 8'hFF, 16'hFFFF);

    write_conn_count(5'd16);
    send_beat(OP_ARRIVAL, 8'd255, 16'd0);
    send_beat(OP_ARRIVAL, 8'd0, 16'd0);
    send_beat(OP_ARRIVAL, 8'd17, 16'd0);
    send_beat(OP_ACK, 8'd0, 16'd0);
    send_beat(OP_ACK, 8'd0, 16'hFFFF);
    send_beat(OP_ACK, 8'd0, 16'd1);
    send_beat(OP_ACK, 8'd0, 16'd1);
    send_beat(OP_ACK, 8'd0, 16'hFFFF);
    send_beat(OP_ARRIVAL, 8'd14, 16'd0);
    send_beat(OP_ACK, 8'd0, 16'hFFFF);

    write_conn_count(5'd3);
    send_beat(OP_ARRIVAL, 8'd200, 16'd0);
    send_beat(OP_ACK, 8'd0, 16'd2);
    send_beat(OP_ACK, 8'd0, 16'hFFFF);

    write_conn_count(5'd31);
    send_beat(OP_ARRIVAL, 8'd255, 16'd0);
    send_beat(OP_ACK, 8'h55, 16'h8000);
    send_beat(OP_ACK, 8'hAA, 16'h7FFF);

    for (p = 0; p < 12; p++) begin
      write_conn_count(phase_n[p]);
      if (p == 1) begin
        hold_req = 1'b1;
        repeat (30) send_beat(OP_ACK, 8'($urandom_range(0, 255)), pick_max_ack());
      end
      if (p == 11) calm = 1'b1;
      random_beats(phase_n[p] == 5'd0 ? 25 : 85);
    end

    drain();
    $display("Run covered %0d beats in, %0d grants checked (%0d fallback grants),",
             ledger.beats, ledger.grants, ledger.fallbacks);
    $display("over %0d conn_count settings including zero, one, full and oversized.",
             ledger.settings);
    if (ledger.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* round_robin_ack_distributor_unit.f */
sv/rrad_pkg.sv
sv/rrad_div.sv
sv/rrad_bank.sv
sv/round_robin_ack_distributor_unit.sv
test/tb.sv
